// ===== hdl/pkst_pkg.sv =====
`default_nettype none
package pkst_pkg;

  localparam int unsigned CELL_W = 24;
  localparam logic [CELL_W-1:0] CELL_MAX = {CELL_W{1'b1}};

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND  = 3'd4;

  // kernel shape codes; anything else is the flat disc
  localparam logic [1:0] SHAPE_GAUSS = 2'd0;
  localparam logic [1:0] SHAPE_CONE  = 2'd1;

  // command codes
  localparam logic CMD_STAMP = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Q1.16 one
  localparam logic [16:0] K_ONE = 17'h10000;

endpackage
`default_nettype wire

// ===== hdl/pkst_ram.sv =====
`default_nettype none
module pkst_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/point_kernel_stamp_raster.sv =====
`default_nettype none
// Point kernel stamp raster. A stamp word (cmd 0) maps pos_x/pos_y (Q0.16 of
// the tile) to a center cell and walks the square of half-size rp around it,
// clipped to the raster; cells with normalized distance above 1 are skipped,
// the rest get kernel(d)*amplitude, blended by max or saturating add into a
// Q8.16 cell. A read word (cmd 1) returns one cell on the output channel and
// clears it; an index past the cell count returns 0. After reset the block
// runs a clearing pass over the raster RAM, one cell per cycle, so in_ready_o
// stays low until every cell has been written; config writes are taken at
// any time (cfg_ready_o is tied high) but must only be issued while idle.
// Work is done by one sequencer driving a shared 1-bit-per-cycle divider and
// square root unit plus a single-port-pair RAM:
//   stamp: setup (S_SETUP1, S_SETUP2), then per visited cell the distance
//          test; a skipped cell moves on, the rest run the 17-step d^2
//          divide, then the table lookup for gaussian or the 17-step square
//          root for cone, multiply and read-modify-write; the center cell
//          (d = 0) skips the divide.
//   read:  RAM read, then the output register once it is free or being read out.
// A finished result sits in the output register while the next word is taken.
module point_kernel_stamp_raster
  import pkst_pkg::*;
#(
  parameter int unsigned RASTER_WIDTH       = 256,
  parameter int unsigned RASTER_HEIGHT      = 256,
  parameter int unsigned KERNEL_TABLE_DEPTH = 256
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  cmd_i,
  input  wire logic [15:0]           pos_x_i,
  input  wire logic [15:0]           pos_y_i,
  input  wire logic [16:0]           point_value_i,
  input  wire logic [15:0]           read_index_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic      [CELL_W-1:0]     cell_value_o
);

  localparam int unsigned CELL_COUNT = RASTER_WIDTH * RASTER_HEIGHT;
  localparam int unsigned AW  = $clog2(CELL_COUNT);
  localparam int unsigned XW  = $clog2(RASTER_WIDTH);
  localparam int unsigned YW  = $clog2(RASTER_HEIGHT);
  localparam int unsigned MW  = (XW > YW) ? XW : YW;
  localparam int unsigned CW  = MW + 3;                      // signed coordinate
  localparam int unsigned RWW = 16 + $clog2(RASTER_WIDTH + 1); // radius * 2^16
  localparam int unsigned DW  = 2 * RWW;                     // radius squared
  localparam int unsigned SW  = 2 * CW;                      // dx^2 + dy^2
  localparam int unsigned NW  = ((SW + 32) > DW) ? (SW + 32) : DW;
  localparam int unsigned KW  = $clog2(KERNEL_TABLE_DEPTH);
  localparam int unsigned TW  = 17 + KW + 1;                 // q * (D-1)
  localparam int unsigned AMW = 18;                          // scaled amplitude

  // exp(-4 i/(D-1)) in Q1.16 from y = x/8 in Q0.31: e^-y by Taylor series,
  // squared three times
  function automatic logic [16:0] gauss_entry(input longint unsigned y);
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned r;
    term = 64'h8000_0000;
    pos  = 64'h8000_0000;
    neg  = 64'd0;
    term = ((term * y) >> 31) / 1;  neg = neg + term;
    term = ((term * y) >> 31) / 2;  pos = pos + term;
    term = ((term * y) >> 31) / 3;  neg = neg + term;
    term = ((term * y) >> 31) / 4;  pos = pos + term;
    term = ((term * y) >> 31) / 5;  neg = neg + term;
    term = ((term * y) >> 31) / 6;  pos = pos + term;
    term = ((term * y) >> 31) / 7;  neg = neg + term;
    term = ((term * y) >> 31) / 8;  pos = pos + term;
    term = ((term * y) >> 31) / 9;  neg = neg + term;
    term = ((term * y) >> 31) / 10; pos = pos + term;
    term = ((term * y) >> 31) / 11; neg = neg + term;
    term = ((term * y) >> 31) / 12; pos = pos + term;
    r = (pos > neg) ? pos - neg : 64'd0;
    if (r > 64'h8000_0000) begin
      r = 64'h8000_0000;
    end
    r = (r * r) >> 31;
    r = (r * r) >> 31;
    r = (r * r) >> 31;
    return 17'((r + 64'd16384) >> 15);
  endfunction

  logic [16:0] gauss_rom [KERNEL_TABLE_DEPTH];

  for (genvar g = 0; g < KERNEL_TABLE_DEPTH; g++) begin : g_rom
    localparam longint unsigned GaussY =
      (64'(g) << 30) / 64'(KERNEL_TABLE_DEPTH - 1);
    localparam logic [16:0] GaussVal = gauss_entry(GaussY);
    assign gauss_rom[g] = GaussVal;
  end

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SETUP1, S_SETUP2, S_CELL, S_TEST, S_DIV, S_KERN,
    S_LUT, S_SQRT, S_MUL, S_WRITE, S_RD, S_OUT
  } state_e;

  state_e state_q;

  // config registers
  logic [1:0]  shape_q;
  logic [15:0] radius_q;
  logic [16:0] amp_q;
  logic        scale_q;
  logic        blend_q;

  // latched word
  logic [15:0] pos_x_q, pos_y_q;
  logic [16:0] pval_q;
  logic [AW-1:0] rd_addr_q;

  // stamp setup
  logic [RWW-1:0] rw_q;
  logic [DW-1:0]  den_q;
  logic [AMW-1:0] a_q;
  logic signed [CW-1:0] cx_q, cy_q, x0_q, x1_q, y1_q, xx_q, yy_q;

  // per-cell datapath
  logic [SW-1:0] s_q;
  logic [AW-1:0] idx_q;
  logic [NW:0]   rem_q;
  logic [16:0]   q_q;
  logic [4:0]    cnt_q;
  logic [KW-1:0] ti_q;
  logic [33:0]   sv_q, sr_q, sbit_q;
  logic [16:0]   kv_q;
  logic [CELL_W-1:0] v_q;

  logic [AW-1:0]     clr_q;
  logic [CELL_W-1:0] hold_q;
  logic              res_valid_q;
  logic [CELL_W-1:0] res_q;

  // RAM ports
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  logic in_acc, rd_in_range, slot_free;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign rd_in_range = 32'(read_index_i) < 32'(CELL_COUNT);
  assign slot_free   = !res_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = res_valid_q;
  assign cell_value_o = res_q;

  // ---- setup arithmetic ----
  logic [16+XW:0] px_prod;
  logic [16+YW:0] py_prod;
  logic [33:0]    ap_prod;
  logic [RWW-1:0] rw_d;
  logic [AMW-1:0] a_d;
  assign px_prod = (17 + XW)'(pos_x_q) * (17 + XW)'(RASTER_WIDTH);
  assign py_prod = (17 + YW)'(pos_y_q) * (17 + YW)'(RASTER_HEIGHT);
  assign ap_prod = 34'(amp_q) * 34'(pval_q);
  assign rw_d    = RWW'(radius_q) * RWW'(RASTER_WIDTH);
  assign a_d     = scale_q ? ap_prod[16 +: AMW] : AMW'(amp_q);

  logic signed [CW-1:0] rp, lo_x, hi_x, lo_y, hi_y;
  logic signed [CW-1:0] x0_d, x1_d, y0_d, y1_d;
  localparam logic signed [CW-1:0] XMax = CW'(RASTER_WIDTH - 1);
  localparam logic signed [CW-1:0] YMax = CW'(RASTER_HEIGHT - 1);
  assign rp   = signed'(CW'(rw_q[RWW-1:16])) + signed'(CW'(1));
  assign lo_x = cx_q - rp;
  assign hi_x = cx_q + rp;
  assign lo_y = cy_q - rp;
  assign hi_y = cy_q + rp;
  assign x0_d = (lo_x < 0) ? '0 : lo_x;
  assign x1_d = (hi_x > XMax) ? XMax : hi_x;
  assign y0_d = (lo_y < 0) ? '0 : lo_y;
  assign y1_d = (hi_y > YMax) ? YMax : hi_y;

  // ---- per-cell arithmetic ----
  logic signed [CW-1:0] dx, dy;
  logic signed [SW-1:0] dx2, dy2;
  logic [SW-1:0] s_d;
  logic [AW-1:0] idx_d;
  assign dx    = xx_q - cx_q;
  assign dy    = yy_q - cy_q;
  assign dx2   = dx * dx;
  assign dy2   = dy * dy;
  assign s_d   = unsigned'(dx2) + unsigned'(dy2);
  assign idx_d = AW'(32'(unsigned'(yy_q[YW-1:0])) * RASTER_WIDTH)
               + AW'(unsigned'(xx_q[XW-1:0]));

  logic [NW:0] s_shift, den_ext, rem_sub;
  logic        skip, div_ge;
  assign s_shift = (NW + 1)'({s_q, 32'd0});
  assign den_ext = (NW + 1)'(den_q);
  assign skip    = s_shift > den_ext;
  assign div_ge  = rem_q >= den_ext;
  assign rem_sub = div_ge ? rem_q - den_ext : rem_q;

  // gaussian table index, rounded and clipped
  logic [TW-1:0] ti_prod;
  logic [TW-1:0] ti_full;
  logic [KW-1:0] ti_d;
  assign ti_prod = TW'(q_q) * TW'(KERNEL_TABLE_DEPTH - 1);
  assign ti_full = (ti_prod + TW'(32768)) >> 16;
  assign ti_d    = (ti_full > TW'(KERNEL_TABLE_DEPTH - 1)) ?
                   KW'(KERNEL_TABLE_DEPTH - 1) : KW'(ti_full);

  // bit-serial square root step
  logic [33:0] sq_try;
  logic        sq_ge;
  assign sq_try = sr_q + sbit_q;
  assign sq_ge  = sv_q >= sq_try;

  logic [16:0] cone_kv;
  assign cone_kv = (sr_q >= 34'(K_ONE)) ? 17'd0 : K_ONE - 17'(sr_q);

  // stamp value; cone takes its kernel straight from the finished root
  logic [16:0] kv_mul;
  logic [34:0] kv_prod;
  logic [20:0] kv_hi;
  logic [CELL_W-1:0] v_d;
  assign kv_mul  = (shape_q == SHAPE_CONE) ? cone_kv : kv_q;
  assign kv_prod = 35'(kv_mul) * 35'(a_q);
  assign kv_hi   = kv_prod[34:14];
  assign v_d     = (kv_hi > 21'(CELL_MAX)) ? CELL_MAX : CELL_W'(kv_hi);

  // blend
  logic [CELL_W:0]   sum;
  logic [CELL_W-1:0] blend_d;
  assign sum     = {1'b0, ram_rdata} + {1'b0, v_q};
  assign blend_d = blend_q ? (sum[CELL_W] ? CELL_MAX : sum[CELL_W-1:0])
                           : ((v_q > ram_rdata) ? v_q : ram_rdata);

  logic last_x, last_cell;
  assign last_x    = (xx_q == x1_q);
  assign last_cell = last_x && (yy_q == y1_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = blend_d;
    ram_re    = 1'b0;
    ram_raddr = idx_q;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      S_IDLE: begin
        if (in_acc && (cmd_i == CMD_READ) && rd_in_range) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(read_index_i);
        end
      end
      S_TEST:  ram_re = 1'b1;
      S_WRITE: ram_we = 1'b1;
      S_RD: begin
        ram_we    = 1'b1;
        ram_waddr = rd_addr_q;
        ram_wdata = '0;
      end
      default: ;
    endcase
  end

  pkst_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q  <= SHAPE_GAUSS;
      radius_q <= 16'd1966;
      amp_q    <= 17'd16384;
      scale_q  <= 1'b0;
      blend_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SHAPE:  shape_q  <= cfg_data_i[1:0];
        CFG_RADIUS: radius_q <= cfg_data_i[15:0];
        CFG_AMP:    amp_q    <= cfg_data_i;
        CFG_SCALE:  scale_q  <= cfg_data_i[0];
        CFG_BLEND:  blend_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      // S_OUT handles its own slot
      if (out_valid_o && out_ready_i && (state_q != S_OUT)) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(CELL_COUNT - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            pos_x_q   <= pos_x_i;
            pos_y_q   <= pos_y_i;
            pval_q    <= point_value_i;
            rd_addr_q <= AW'(read_index_i);
            if (cmd_i == CMD_STAMP) begin
              state_q <= S_SETUP1;
            end else if (rd_in_range) begin
              state_q <= S_RD;
            end else begin
              hold_q  <= '0;
              state_q <= S_OUT;
            end
          end
        end
        S_SETUP1: begin
          rw_q    <= rw_d;
          a_q     <= a_d;
          cx_q    <= signed'(CW'(px_prod[16 +: XW]));
          cy_q    <= signed'(CW'(py_prod[16 +: YW]));
          state_q <= S_SETUP2;
        end
        S_SETUP2: begin
          den_q   <= DW'(rw_q) * DW'(rw_q);
          x0_q    <= x0_d;
          x1_q    <= x1_d;
          y1_q    <= y1_d;
          xx_q    <= x0_d;
          yy_q    <= y0_d;
          state_q <= S_CELL;
        end
        S_CELL: begin
          s_q     <= s_d;
          idx_q   <= idx_d;
          state_q <= S_TEST;
        end
        S_TEST: begin
          if (skip) begin
            // outside the unit circle: next cell
            if (last_cell) begin
              state_q <= S_IDLE;
            end else begin
              state_q <= S_CELL;
              if (last_x) begin
                xx_q <= x0_q;
                yy_q <= yy_q + signed'(CW'(1));
              end else begin
                xx_q <= xx_q + signed'(CW'(1));
              end
            end
          end else if ((s_q == '0) || (den_q == '0)) begin
            q_q     <= '0;
            state_q <= S_KERN;
          end else begin
            rem_q   <= s_shift;
            q_q     <= '0;
            cnt_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle, 17 bits
          q_q   <= {q_q[15:0], div_ge};
          rem_q <= {rem_sub[NW-1:0], 1'b0};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd16) begin
            state_q <= S_KERN;
          end
        end
        S_KERN: begin
          case (shape_q)
            SHAPE_GAUSS: begin
              ti_q    <= ti_d;
              state_q <= S_LUT;
            end
            SHAPE_CONE: begin
              sv_q    <= {1'b0, q_q, 16'd0};
              sr_q    <= '0;
              sbit_q  <= 34'h1_0000_0000;
              state_q <= S_SQRT;
            end
            default: begin
              kv_q    <= K_ONE;
              state_q <= S_MUL;
            end
          endcase
        end
        S_LUT: begin
          kv_q    <= gauss_rom[ti_q];
          state_q <= S_MUL;
        end
        S_SQRT: begin
          if (sq_ge) begin
            sv_q <= sv_q - sq_try;
            sr_q <= (sr_q >> 1) + sbit_q;
          end else begin
            sr_q <= sr_q >> 1;
          end
          sbit_q <= sbit_q >> 2;
          if (sbit_q == 34'd1) begin
            state_q <= S_MUL;
            // final root is ready next cycle; use it in the multiply state
          end
        end
        S_MUL: begin
          state_q <= S_WRITE;
        end
        S_WRITE: begin
          if (last_cell) begin
            state_q <= S_IDLE;
          end else begin
            state_q <= S_CELL;
            if (last_x) begin
              xx_q <= x0_q;
              yy_q <= yy_q + signed'(CW'(1));
            end else begin
              xx_q <= xx_q + signed'(CW'(1));
            end
          end
        end
        S_RD: begin
          hold_q  <= ram_rdata;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (slot_free) begin
            res_valid_q <= 1'b1;
            res_q       <= hold_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // stamp value register
  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL) begin
      v_q <= v_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pkst_checker.sv =====
`default_nettype none
module pkst_checker
  import pkst_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_o,
  input wire logic                  cmd_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire logic [CELL_W-1:0]     cell_value_o
);

  // a result word holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cell_value_o))
    else $error("result word dropped or changed while stalled");

  // every accepted word takes the sequencer out of idle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken on back-to-back cycles");

  // a new result only appears while a word is in flight
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result word without a pending read");

  // stamp words never produce a result directly
  a_stamp_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (cmd_i == CMD_STAMP) && !out_valid_o
    |=> !out_valid_o)
    else $error("result word after a stamp");

endmodule

bind point_kernel_stamp_raster pkst_checker u_pkst_checker (.*);
`default_nettype wire

// ===== verif/point_kernel_stamp_raster_tb.sv =====
`timescale 1ns / 1ps

module point_kernel_stamp_raster_tb;
  import pkst_pkg::*;

  localparam int unsigned RW        = 256;
  localparam int unsigned RH        = 256;
  localparam int unsigned KDEPTH    = 256;
  localparam int unsigned NCELLS    = RW * RH;
  localparam longint      LIMIT     = 20_000_000;
  localparam int unsigned NPHASES   = 13;
  localparam int unsigned PHASE_LEN = 136;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  cmd_i;
  logic [15:0]           pos_x_i;
  logic [15:0]           pos_y_i;
  logic [16:0]           point_value_i;
  logic [15:0]           read_index_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [CELL_W-1:0]     cell_value_o;

  point_kernel_stamp_raster #(
    .RASTER_WIDTH(RW), .RASTER_HEIGHT(RH), .KERNEL_TABLE_DEPTH(KDEPTH)
  ) dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .cmd_i, .pos_x_i, .pos_y_i, .point_value_i,
    .read_index_i, .out_valid_o, .out_ready_i, .cell_value_o
  );

  // ---------------------------------------------------------------------
  // Shadow copy of the raster and the register file
  // ---------------------------------------------------------------------
  logic [CELL_W-1:0] cell_mirror [NCELLS];
  logic [16:0]       gauss_lut   [KDEPTH];
  logic [1:0]        sh_shape;
  logic [15:0]       sh_radius;
  logic [16:0]       sh_amp;
  logic              sh_scale;
  logic              sh_blend;

  logic [CELL_W-1:0] cells_due[$];   // read words still owed by the block
  int                errors;
  longint            cycles;
  int                send_idle_pct;
  int                recv_idle_pct;
  bit                hold_req;
  int                recent_cx, recent_cy;

  // exp(-4 i/(D-1)) in Q1.16: Taylor series of e^-(x/8), then squared three times
  function automatic logic [16:0] gauss_value(int unsigned i);
    longint unsigned y, term, pos, neg, r;
    y    = (longint'(i) << 30) / (KDEPTH - 1);
    term = 64'h8000_0000;
    pos  = 64'h8000_0000;
    neg  = 0;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * y) >> 31) / k;
      if (k % 2) neg += term;
      else       pos += term;
    end
    r = (pos > neg) ? pos - neg : 0;
    if (r > 64'h8000_0000) r = 64'h8000_0000;
    for (int n = 0; n < 3; n++) r = (r * r) >> 31;
    return 17'((r + (1 << 14)) >> 15);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 32;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // d^2 in Q1.16: s*2^48 / rw^2, done as a long division
  function automatic longint unsigned d2_q16(longint unsigned s, longint unsigned den);
    longint unsigned rem, q;
    if (s == 0 || den == 0) return 0;
    rem = s << 32;
    q   = rem / den;
    rem = rem % den;
    for (int n = 0; n < 16; n++) begin
      rem <<= 1;
      q   <<= 1;
      if (rem >= den) begin
        rem -= den;
        q   |= 1;
      end
    end
    return q;
  endfunction

  task automatic splat_point(logic [15:0] px, logic [15:0] py, logic [16:0] pv);
    longint unsigned rw, den, a, s, q, kv, v, ti, sum;
    longint          rp, cx, cy, x0, x1, y0, y1, dx, dy;
    int              idx;
    rw  = longint'(sh_radius) * RW;
    den = rw * rw;
    rp  = longint'(rw >> 16) + 1;
    cx  = longint'((longint'(px) * RW) >> 16);
    cy  = longint'((longint'(py) * RH) >> 16);
    recent_cx = int'(cx);
    recent_cy = int'(cy);
    a = sh_amp;
    if (sh_scale) a = (a * pv) >> 16;
    x0 = (cx - rp < 0) ? 0 : cx - rp;
    y0 = (cy - rp < 0) ? 0 : cy - rp;
    x1 = (cx + rp > RW - 1) ? RW - 1 : cx + rp;
    y1 = (cy + rp > RH - 1) ? RH - 1 : cy + rp;
    for (longint yy = y0; yy <= y1; yy++) begin
      dy = yy - cy;
      for (longint xx = x0; xx <= x1; xx++) begin
        dx = xx - cx;
        s  = longint'(dx * dx + dy * dy);
        if ((s << 32) > den) continue;
        q = d2_q16(s, den);
        if (sh_shape == SHAPE_GAUSS) begin
          ti = (q * (KDEPTH - 1) + 32768) >> 16;
          if (ti > KDEPTH - 1) ti = KDEPTH - 1;
          kv = gauss_lut[ti];
        end else if (sh_shape == SHAPE_CONE) begin
          v  = root_floor(q << 16);
          kv = (v >= 65536) ? 0 : 65536 - v;
        end else begin
          kv = K_ONE;
        end
        v = (kv * a) >> 14;
        if (v > CELL_MAX) v = CELL_MAX;
        idx = int'(yy) * RW + int'(xx);
        if (sh_blend) begin
          sum = longint'(cell_mirror[idx]) + v;
          cell_mirror[idx] = (sum > CELL_MAX) ? CELL_MAX : CELL_W'(sum);
        end else if (v > cell_mirror[idx]) begin
          cell_mirror[idx] = CELL_W'(v);
        end
      end
    end
  endtask

  function automatic logic [CELL_W-1:0] fetch_and_clear(logic [15:0] ri);
    logic [CELL_W-1:0] v;
    v = 0;
    if (ri < NCELLS) begin
      v = cell_mirror[ri];
      cell_mirror[ri] = 0;
    end
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [CELL_W-1:0] want,
                                 logic [CELL_W-1:0] got);
    $display("mismatch %s: want %0d got %0d at cycle %0d", what, want, got, cycles);
    errors++;
  endtask

  // ---------------------------------------------------------------------
  // Clock, reset, cycle limit
  // ---------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------
  int hold_left;
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker: oldest expectation first
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cells_due.size() == 0) begin
        report_mismatch("unexpected cell_value", '0, cell_value_o);
      end else begin
        logic [CELL_W-1:0] want;
        want = cells_due.pop_front();
        if (cell_value_o !== want) report_mismatch("cell_value", want, cell_value_o);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------
  task automatic send_word(logic c, logic [15:0] x, logic [15:0] y, logic [16:0] v,
                           logic [15:0] ri, bit typed = 0,
                           logic [CELL_W-1:0] typed_val = '0);
    logic [CELL_W-1:0] got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= c;
    pos_x_i       <= x;
    pos_y_i       <= y;
    point_value_i <= v;
    read_index_i  <= ri;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (c == CMD_STAMP) begin
      splat_point(x, y, v);
    end else begin
      got = fetch_and_clear(ri);
      cells_due = {cells_due, (typed ? typed_val : got)};
    end
  endtask

  // A stamp owes no word, so chase it with a read: once that word is back
  // the sequencer is idle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (cells_due.size() != 0) @(posedge clk_i);
    send_word(CMD_READ, '0, '0, '0, 16'($urandom));
    in_valid_i <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] ri, logic [CFG_DATA_W-1:0] d);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= ri;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (ri)
      CFG_SHAPE:  sh_shape  = d[1:0];
      CFG_RADIUS: sh_radius = d[15:0];
      CFG_AMP:    sh_amp    = d[16:0];
      CFG_SCALE:  sh_scale  = d[0];
      CFG_BLEND:  sh_blend  = d[0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Directed rows: a register write, or a word with optional typed answer
  // ---------------------------------------------------------------------
  typedef struct {
    bit                    is_reg;
    logic [CFG_IDX_W-1:0]  ridx;
    logic [CFG_DATA_W-1:0] rdata;
    logic                  c;
    logic [15:0]           x;
    logic [15:0]           y;
    logic [16:0]           v;
    logic [15:0]           ri;
    bit                    typed;
    logic [CELL_W-1:0]     want;
  } row_t;

  localparam int NROWS = 34;
  row_t dir_rows [NROWS] = '{
    // fresh raster reads zero at both ends
    '{0, CFG_SHAPE, 0, CMD_READ,  0, 0, 0, 0,     1, 0},
    '{0, CFG_SHAPE, 0, CMD_READ,  0, 0, 0, 65535, 1, 0},
    // gaussian corner stamps, peak is exactly 1.0
    '{0, CFG_SHAPE, 0, CMD_STAMP, 0, 0, 0, 0,     0, 0},
    '{0, CFG_SHAPE, 0, CMD_READ,  0, 0, 0, 0,     1, 65536},
    '{0, CFG_SHAPE, 0, CMD_READ,  0, 0, 0, 0,     1, 0},
    '{0, CFG_SHAPE, 0, CMD_READ,  0, 0, 0, 1,     0, 0},
    '{0, CFG_SHAPE, 0, CMD_STAMP, 16'hFFFF, 16'hFFFF, 17'h0FFFF, 0, 0, 0},
    '{0, CFG_SHAPE, 0, CMD_READ,  0, 0, 0, 65535, 1, 65536},
    '{0, CFG_SHAPE, 0, CMD_READ,  0, 0, 0, 65534, 0, 0},
    '{0, CFG_SHAPE, 0, CMD_READ,  0, 0, 0, 65279, 0, 0},
    // cone
    '{1, CFG_SHAPE, SHAPE_CONE, 0, 0, 0, 0, 0, 0, 0},
    '{0, CFG_SHAPE, 0, CMD_STAMP, 16'h8000, 16'h8000, 0, 0, 0, 0},
    '{0, CFG_SHAPE, 0, CMD_READ,  0, 0, 0, 32896, 1, 65536},
    '{0, CFG_SHAPE, 0, CMD_READ,  0, 0, 0, 32897, 0, 0},
    '{0, CFG_SHAPE, 0, CMD_READ,  0, 0, 0, 33152, 0, 0},
    // shape code three acts as disc; zero radius hits the center only
    '{1, CFG_SHAPE,  3, 0, 0, 0, 0, 0, 0, 0},
    '{1, CFG_RADIUS, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, CFG_SHAPE, 0, CMD_STAMP, 16'h8000, 16'h8000, 0, 0, 0, 0},
    '{0, CFG_SHAPE, 0, CMD_READ,  0, 0, 0, 32896, 1, 65536},
    '{0, CFG_SHAPE, 0, CMD_READ,  0, 0, 0, 32897, 1, 0},
    // value scaling, full and zero
    '{1, CFG_SCALE, 1,     0, 0, 0, 0, 0, 0, 0},
    '{1, CFG_AMP,   65536, 0, 0, 0, 0, 0, 0, 0},
    '{0, CFG_SHAPE, 0, CMD_STAMP, 16'h8000, 16'h8000, 17'h10000, 0, 0, 0},
    '{0, CFG_SHAPE, 0, CMD_READ,  0, 0, 0, 32896, 1, 262144},
    '{0, CFG_SHAPE, 0, CMD_STAMP, 16'h8000, 16'h8000, 0, 0, 0, 0},
    '{0, CFG_SHAPE, 0, CMD_READ,  0, 0, 0, 32896, 1, 0},
    // widest radius in this bench, add blend, flat disc from the corner
    '{1, CFG_SCALE,  0,     0, 0, 0, 0, 0, 0, 0},
    '{1, CFG_BLEND,  1,     0, 0, 0, 0, 0, 0, 0},
    '{1, CFG_SHAPE,  2,     0, 0, 0, 0, 0, 0, 0},
    '{1, CFG_RADIUS, 32768, 0, 0, 0, 0, 0, 0, 0},
    '{0, CFG_SHAPE, 0, CMD_STAMP, 0, 0, 0, 0, 0, 0},
    '{0, CFG_SHAPE, 0, CMD_READ,  0, 0, 0, 0,     1, 262144},
    '{0, CFG_SHAPE, 0, CMD_READ,  0, 0, 0, 25700, 0, 0},
    '{0, CFG_SHAPE, 0, CMD_READ,  0, 0, 0, 33000, 0, 0}
  };

  task automatic random_regs();
    int pick;
    write_reg(CFG_SHAPE, CFG_DATA_W'($urandom_range(3)));
    pick = $urandom_range(99);
    // keep stamps small so the run stays short
    if (pick < 10)      write_reg(CFG_RADIUS, CFG_DATA_W'($urandom_range(1) ? 0 : 66));
    else if (pick < 85) write_reg(CFG_RADIUS, CFG_DATA_W'($urandom_range(66, 400)));
    else                write_reg(CFG_RADIUS, CFG_DATA_W'($urandom_range(400, 900)));
    write_reg(CFG_AMP,   CFG_DATA_W'($urandom_range(131071)));
    write_reg(CFG_SCALE, CFG_DATA_W'($urandom_range(1)));
    write_reg(CFG_BLEND, CFG_DATA_W'($urandom_range(1)));
  endtask

  task automatic random_word();
    logic [15:0] x, y, ri;
    logic [16:0] v;
    int          cx, cy;
    x  = 16'($urandom);
    y  = 16'($urandom);
    v  = ($urandom_range(99) < 80) ? 17'($urandom_range(65536)) : 17'($urandom);
    if ($urandom_range(1)) begin
      // re-hit the last spot now and then so blends stack up
      if ($urandom_range(99) < 15) begin
        x = 16'(recent_cx << 8);
        y = 16'(recent_cy << 8);
      end
      send_word(CMD_STAMP, x, y, v, 16'($urandom));
    end else begin
      if ($urandom_range(99) < 65) begin
        cx = recent_cx + $urandom_range(6) - 3;
        cy = recent_cy + $urandom_range(6) - 3;
        cx = (cx < 0) ? 0 : (cx > RW - 1) ? RW - 1 : cx;
        cy = (cy < 0) ? 0 : (cy > RH - 1) ? RH - 1 : cy;
        ri = 16'(cy * RW + cx);
      end else begin
        ri = 16'($urandom);
      end
      send_word(CMD_READ, x, y, v, ri);
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    errors        = 0;
    cycles        = 0;
    hold_req      = 1'b0;
    hold_left     = 0;
    recent_cx     = 0;
    recent_cy     = 0;
    send_idle_pct = 26;
    recv_idle_pct = 58;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    cmd_i         = CMD_STAMP;
    pos_x_i       = '0;
    pos_y_i       = '0;
    point_value_i = '0;
    read_index_i  = '0;
    out_ready_i   = 1'b0;
    for (int i = 0; i < NCELLS; i++) cell_mirror[i] = '0;
    for (int i = 0; i < KDEPTH; i++) gauss_lut[i] = gauss_value(i);
    sh_shape  = SHAPE_GAUSS;
    sh_radius = 16'd1966;
    sh_amp    = 17'd16384;
    sh_scale  = 1'b0;
    sh_blend  = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_reg) write_reg(dir_rows[i].ridx, dir_rows[i].rdata);
      else send_word(dir_rows[i].c, dir_rows[i].x, dir_rows[i].y, dir_rows[i].v,
                     dir_rows[i].ri, dir_rows[i].typed, dir_rows[i].want);
    end

    // add-blend saturation: 524284 (just under 2^19) per hit, so 40 hits pin the cell at max
    write_reg(CFG_RADIUS, 0);
    write_reg(CFG_AMP, 17'h1FFFF);
    for (int i = 0; i < 40; i++) send_word(CMD_STAMP, 16'h1234, 16'hABCD, '0, '0);
    send_word(CMD_READ, '0, '0, '0, 16'((16'hABCD >> 8) * RW + (16'h1234 >> 8)),
              1, CELL_MAX);
    // zero amplitude adds nothing to an untouched cell
    write_reg(CFG_AMP, 0);
    send_word(CMD_STAMP, 16'hC800, 16'hC800, 17'h1FFFF, '0);
    send_word(CMD_READ, '0, '0, '0, 16'(200 * RW + 200), 1, 0);

    for (int p = 0; p < NPHASES; p++) begin
      if (p < 4) begin
        send_idle_pct = 26;
        recv_idle_pct = 58;
      end else if (p < 8) begin
        send_idle_pct = 58;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_regs();
      // long receiver hold while reads keep coming: the block backs up
      if (p == 9) begin
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++) send_word(CMD_READ, '0, '0, '0, 16'($urandom));
      end
      for (int i = 0; i < PHASE_LEN; i++) random_word();
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
